### hw/rtl/srit_pkg.sv
// ----------------------------------------------------------------------------
// srit_pkg
// Shared widths and types for the segment / rectangle intersection test.
// ----------------------------------------------------------------------------
package srit_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
	localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
	localparam int SUM_WIDTH   = PROD_WIDTH + 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [SUM_WIDTH-1:0]   sum_t;

	// load enables for the stages inside each edge unit
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} pipe_en_t;

endpackage

### hw/rtl/srit_edge_unit.sv
// ----------------------------------------------------------------------------
// srit_edge_unit
// Tests one edge line u = e: does the segment cross it strictly, and does
// the crossing fall within the span s0..s1? Exact, by cross-multiplication.
// ----------------------------------------------------------------------------
module srit_edge_unit (
	input  logic              clk,
	input  srit_pkg::pipe_en_t en,
	input  srit_pkg::coord_t  u1,
	input  srit_pkg::coord_t  v1,
	input  srit_pkg::coord_t  u2,
	input  srit_pkg::coord_t  v2,
	input  srit_pkg::coord_t  e,
	input  srit_pkg::coord_t  s0,
	input  srit_pkg::coord_t  s1,
	output logic              hit
);
	import srit_pkg::*;

	diff_t du_s2, dv_s2, t_s2, a0_s2, a1_s2;
	logic  cross_s2, up_s2;

	prod_t lead_s3, p0_s3, p1_s3;
	logic  cross_s3, up_s3;

	sum_t n0, n1;
	logic n0_neg, n0_zero, n1_neg, n1_zero, ok0, ok1;

	// differences and the strict crossing test
	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			du_s2    <= diff_t'(u2) - diff_t'(u1);
			dv_s2    <= diff_t'(v2) - diff_t'(v1);
			t_s2     <= diff_t'(e) - diff_t'(u1);
			a0_s2    <= diff_t'(v1) - diff_t'(s0);
			a1_s2    <= diff_t'(v1) - diff_t'(s1);
			cross_s2 <= (u1 > e) != (u2 > e);
			up_s2    <= u2 >= u1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			lead_s3  <= prod_t'(dv_s2) * prod_t'(t_s2);
			p0_s3    <= prod_t'(a0_s2) * prod_t'(du_s2);
			p1_s3    <= prod_t'(a1_s2) * prod_t'(du_s2);
			cross_s3 <= cross_s2;
			up_s3    <= up_s2;
		end
	end

	// n0, n1 carry the signs of (cross - s0) * du and (cross - s1) * du
	assign n0      = sum_t'(p0_s3) + sum_t'(lead_s3);
	assign n1      = sum_t'(p1_s3) + sum_t'(lead_s3);
	assign n0_neg  = n0[SUM_WIDTH-1];
	assign n1_neg  = n1[SUM_WIDTH-1];
	assign n0_zero = (n0 == '0);
	assign n1_zero = (n1 == '0);
	assign ok0     = up_s3 ? !n0_neg : (n0_neg || n0_zero);
	assign ok1     = up_s3 ? (n1_neg || n1_zero) : !n1_neg;
	assign hit     = cross_s3 && ok0 && ok1;

endmodule

### hw/rtl/segment_rect_intersect_test_unit.sv
// ----------------------------------------------------------------------------
// segment_rect_intersect_test_unit
// Decides whether a line segment touches an axis-aligned rectangle.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with the rectangle bounds and the two
// segment endpoints. A request is taken at a clock edge with in_valid high
// and in_stall low. Output channel: out_valid / out_stall with intersects.
// Every request gives exactly one result, in order.
// Path: a taken request moves through the input register, difference
// stage, product stage and result register in turn.
// Throughput: one request per cycle while the receiver does not stall;
// each stage: one 33 x 33 signed multiply or one 67-bit add and sign test.
// When the receiver stalls, the result holds and the stages behind it keep
// filling bubbles; in_stall rises only once every stage holds a request.
// Reset clears all valid flags; the block is then empty and ready.
// ----------------------------------------------------------------------------
module segment_rect_intersect_test_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  srit_pkg::coord_t rect_left,
	input  srit_pkg::coord_t rect_top,
	input  srit_pkg::coord_t rect_right,
	input  srit_pkg::coord_t rect_bottom,
	input  srit_pkg::coord_t start_x,
	input  srit_pkg::coord_t start_y,
	input  srit_pkg::coord_t end_x,
	input  srit_pkg::coord_t end_y,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             intersects
);
	import srit_pkg::*;

	coord_t l_s1, t_s1, r_s1, b_s1, x1_s1, y1_s1, x2_s1, y2_s1;
	logic   v_s1, v_s2, v_s3, out_valid_q, intersects_q;
	logic   inside_s2, inside_s3;
	logic   s1_free, s2_free, s3_free, out_free;
	logic   inside_d;
	logic   hit_left, hit_right, hit_top, hit_bottom;
	pipe_en_t en;

	// a stage may load when it is empty or its contents move on
	assign out_free = !(out_valid_q && out_stall);
	assign s3_free  = !v_s3 || out_free;
	assign s2_free  = !v_s2 || s3_free;
	assign s1_free  = !v_s1 || s2_free;
	assign in_stall = !s1_free;

	assign en.ld_s2 = v_s1 && s2_free;
	assign en.ld_s3 = v_s2 && s3_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free)  v_s1        <= in_valid;
			if (s2_free)  v_s2        <= v_s1;
			if (s3_free)  v_s3        <= v_s2;
			if (out_free) out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_free) begin
			l_s1  <= rect_left;
			t_s1  <= rect_top;
			r_s1  <= rect_right;
			b_s1  <= rect_bottom;
			x1_s1 <= start_x;
			y1_s1 <= start_y;
			x2_s1 <= end_x;
			y2_s1 <= end_y;
		end
	end

	// either endpoint inside, bounds inclusive
	assign inside_d = ((x1_s1 >= l_s1) && (x1_s1 <= r_s1) &&
	                   (y1_s1 >= t_s1) && (y1_s1 <= b_s1)) ||
	                  ((x2_s1 >= l_s1) && (x2_s1 <= r_s1) &&
	                   (y2_s1 >= t_s1) && (y2_s1 <= b_s1));

	always_ff @(posedge clk) begin
		if (en.ld_s2) inside_s2 <= inside_d;
		if (en.ld_s3) inside_s3 <= inside_s2;
	end

	srit_edge_unit u_edge_left (
		.clk(clk), .en(en),
		.u1(x1_s1), .v1(y1_s1), .u2(x2_s1), .v2(y2_s1),
		.e(l_s1), .s0(t_s1), .s1(b_s1), .hit(hit_left)
	);

	srit_edge_unit u_edge_right (
		.clk(clk), .en(en),
		.u1(x1_s1), .v1(y1_s1), .u2(x2_s1), .v2(y2_s1),
		.e(r_s1), .s0(t_s1), .s1(b_s1), .hit(hit_right)
	);

	srit_edge_unit u_edge_top (
		.clk(clk), .en(en),
		.u1(y1_s1), .v1(x1_s1), .u2(y2_s1), .v2(x2_s1),
		.e(t_s1), .s0(l_s1), .s1(r_s1), .hit(hit_top)
	);

	srit_edge_unit u_edge_bottom (
		.clk(clk), .en(en),
		.u1(y1_s1), .v1(x1_s1), .u2(y2_s1), .v2(x2_s1),
		.e(b_s1), .s0(l_s1), .s1(r_s1), .hit(hit_bottom)
	);

	always_ff @(posedge clk) begin
		if (v_s3 && out_free) begin
			intersects_q <= inside_s3 || hit_left || hit_right || hit_top || hit_bottom;
		end
	end

	assign out_valid  = out_valid_q;
	assign intersects = intersects_q;

endmodule

### tb/sv/segment_rect_intersect_checker.sv
// ----------------------------------------------------------------------------
// segment_rect_intersect_checker
// Watches both channels of the segment / rectangle test unit, predicts the
// intersects flag of every accepted request with exact wide arithmetic, and
// compares it with the results in order.
// ----------------------------------------------------------------------------
module segment_rect_intersect_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  srit_pkg::coord_t rect_left,
	input  srit_pkg::coord_t rect_top,
	input  srit_pkg::coord_t rect_right,
	input  srit_pkg::coord_t rect_bottom,
	input  srit_pkg::coord_t start_x,
	input  srit_pkg::coord_t start_y,
	input  srit_pkg::coord_t end_x,
	input  srit_pkg::coord_t end_y,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic             intersects,
	output int               fail_count,
	output int               hits_pending
);
	import srit_pkg::*;

	// wide enough for a 33 x 33 product plus a sum, with room to spare
	typedef logic signed [95:0] wide_t;

	bit hit_q[$];
	int n_fail    = 0;
	int n_pending = 0;

	assign fail_count   = n_fail;
	assign hits_pending = n_pending;

	function automatic bit point_in_rect(coord_t x, coord_t y, coord_t l, coord_t t,
			coord_t r, coord_t b);
		return x >= l && x <= r && y >= t && y <= b;
	endfunction

	// segment crosses the line u = e strictly, and the crossing lies in s0..s1
	function automatic bit crosses_edge(wide_t u1, wide_t v1, wide_t u2, wide_t v2,
			wide_t e, wide_t s0, wide_t s1);
		wide_t du, dv, lead, n0, n1;
		bit    ok0, ok1;
		if ((e < u1) == (e < u2))
			return 1'b0;
		du   = u2 - u1;
		dv   = v2 - v1;
		lead = dv * (e - u1);
		// (crossing - s) * du, kept exact so no division is needed
		n0   = (v1 - s0) * du + lead;
		n1   = (v1 - s1) * du + lead;
		if (du >= 0) begin
			ok0 = n0 >= 0;
			ok1 = n1 <= 0;
		end else begin
			ok0 = n0 <= 0;
			ok1 = n1 >= 0;
		end
		return ok0 && ok1;
	endfunction

	function automatic bit segment_hits_rect(coord_t l, coord_t t, coord_t r, coord_t b,
			coord_t x1, coord_t y1, coord_t x2, coord_t y2);
		return point_in_rect(x1, y1, l, t, r, b) || point_in_rect(x2, y2, l, t, r, b)
			|| crosses_edge(x1, y1, x2, y2, l, t, b)
			|| crosses_edge(x1, y1, x2, y2, r, t, b)
			|| crosses_edge(y1, x1, y2, x2, t, l, r)
			|| crosses_edge(y1, x1, y2, x2, b, l, r);
	endfunction

	always @(posedge clk) begin
		bit want;
		if (arst_n) begin
			// compare before push so a fresh request never pairs with a stray result
			if (out_valid && !out_stall) begin
				if (hit_q.size() == 0) begin
					$error("intersects: result %0b with no request waiting", intersects);
					n_fail <= n_fail + 1;
				end else begin
					want = hit_q.pop_front();
					if (intersects !== want) begin
						$error("intersects: expected %0b, actual %0b", want, intersects);
						n_fail <= n_fail + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				hit_q.push_back(segment_hits_rect(rect_left, rect_top, rect_right,
					rect_bottom, start_x, start_y, end_x, end_y));
			n_pending <= hit_q.size();
		end
	end

endmodule

### tb/sv/segment_rect_intersect_test_unit_tb.sv
// ----------------------------------------------------------------------------
// segment_rect_intersect_test_unit_tb
// Drives directed and random segment / rectangle requests into the test
// unit under random gaps and receiver stalls, including one long hold-off,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module segment_rect_intersect_test_unit_tb;

	import srit_pkg::*;

	localparam int     RUN_LIMIT  = 600000;
	localparam int     RAND_COUNT = 1150;
	localparam int     HOLD_LEN   = 150;
	localparam coord_t CMIN       = 32'sh8000_0000;
	localparam coord_t CMAX       = 32'sh7fff_ffff;

	typedef struct {
		coord_t l, t, r, b;
		coord_t x1, y1, x2, y2;
	} seg_req_t;

	logic   clk         = 1'b0;
	logic   arst_n      = 1'b0;
	logic   in_valid    = 1'b0;
	logic   out_stall   = 1'b0;
	logic   drain_hold  = 1'b0;
	coord_t rect_left   = '0;
	coord_t rect_top    = '0;
	coord_t rect_right  = '0;
	coord_t rect_bottom = '0;
	coord_t start_x     = '0;
	coord_t start_y     = '0;
	coord_t end_x       = '0;
	coord_t end_y       = '0;
	logic   in_stall;
	logic   out_valid;
	logic   intersects;
	int     fail_count;
	int     hits_pending;
	int     cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	segment_rect_intersect_test_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.rect_left(rect_left), .rect_top(rect_top),
		.rect_right(rect_right), .rect_bottom(rect_bottom),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.out_valid(out_valid), .out_stall(out_stall), .intersects(intersects)
	);

	segment_rect_intersect_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.rect_left(rect_left), .rect_top(rect_top),
		.rect_right(rect_right), .rect_bottom(rect_bottom),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.out_valid(out_valid), .out_stall(out_stall), .intersects(intersects),
		.fail_count(fail_count), .hits_pending(hits_pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: runs of ready and stall, one long hold-off on request
	initial begin
		int  run_left;
		int  hold_left;
		int  r;
		bit  hold_done;
		run_left  = 0;
		hold_left = 0;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (drain_hold && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				r = $urandom_range(0, 9);
				if (r < 5) begin
					out_stall <= 1'b0;
					run_left = $urandom_range(0, 6);
				end else if (r < 7) begin
					out_stall <= 1'b0;
					run_left = $urandom_range(20, 60);
				end else if (r < 9) begin
					out_stall <= 1'b1;
					run_left = $urandom_range(0, 3);
				end else begin
					out_stall <= 1'b1;
					run_left = $urandom_range(10, 40);
				end
			end
		end
	end

	function automatic coord_t pick_coord(int scale);
		int r;
		case (scale)
			0: return $urandom_range(0, 32) - 16;
			1: return $urandom_range(0, 2 ** 21) - 2 ** 20;
			default: begin
				r = $urandom_range(0, 15);
				if (r == 0)
					return CMIN;
				if (r == 1)
					return CMAX;
				return $urandom;
			end
		endcase
	endfunction

	task automatic send_req(input seg_req_t q, input bit dense);
		int r;
		int gap;
		rect_left   <= q.l;
		rect_top    <= q.t;
		rect_right  <= q.r;
		rect_bottom <= q.b;
		start_x     <= q.x1;
		start_y     <= q.y1;
		end_x       <= q.x2;
		end_y       <= q.y2;
		in_valid    <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		r = $urandom_range(0, 9);
		if (dense || r < 6)
			gap = 0;
		else if (r < 9)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		// keep valid high when the next request follows at once
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		seg_req_t q;
		coord_t   a, c, cx, cy;
		int       scale, kind, dx, dy, k1, k2;
		bit       dense;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, corners, span ends, degenerate and unnormalized cases
		send_req('{0, 0, 0, 0, 0, 0, 0, 0}, 1'b0);
		send_req('{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b0);
		send_req('{0, 0, 0, 0, CMIN, CMIN, CMAX, CMAX}, 1'b0);
		send_req('{1, 1, 1, 1, CMIN, CMAX, CMAX, CMIN}, 1'b0);
		send_req('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b0);
		send_req('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b0);
		send_req('{CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX}, 1'b0);
		send_req('{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
			32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa}, 1'b0);
		send_req('{-10, -10, 10, 10, -20, 0, 20, 0}, 1'b0);
		send_req('{-10, -10, 10, 10, 0, -20, 0, 20}, 1'b0);
		send_req('{-10, -10, 10, 10, 20, 3, -20, -3}, 1'b0);
		send_req('{-10, -10, 10, 10, -20, 0, -10, 5}, 1'b0);
		send_req('{-10, -10, 10, 10, -12, -8, -8, -12}, 1'b0);
		send_req('{-10, -10, 10, 10, -12, -9, -9, -12}, 1'b0);
		send_req('{-10, -10, 10, 10, -20, 10, 20, 10}, 1'b0);
		send_req('{-10, -10, 10, 10, 11, 0, 11, 0}, 1'b0);
		send_req('{-10, -10, 10, 10, -3, 4, -3, 4}, 1'b0);
		send_req('{10, -10, -10, 10, 0, 0, 0, 0}, 1'b0);
		send_req('{10, -10, -10, 10, -20, 0, 20, 0}, 1'b0);
		send_req('{-10, 10, 10, -10, 0, -20, 0, 20}, 1'b0);

		dense = 1'b0;
		for (int i = 0; i < RAND_COUNT; i++) begin
			if (i % 64 == 0)
				dense = $urandom_range(0, 3) == 0;
			if (i == 300) begin
				drain_hold <= 1'b1;
				dense = 1'b1;
			end
			scale = $urandom_range(0, 9);
			scale = scale < 5 ? 0 : (scale < 8 ? 1 : 2);
			a = pick_coord(scale);
			c = pick_coord(scale);
			// mostly normalized rectangles, a few with swapped bounds
			if ((a > c) != ($urandom_range(0, 24) == 0)) begin
				q.l = c;
				q.r = a;
			end else begin
				q.l = a;
				q.r = c;
			end
			a = pick_coord(scale);
			c = pick_coord(scale);
			if ((a > c) != ($urandom_range(0, 24) == 0)) begin
				q.t = c;
				q.b = a;
			end else begin
				q.t = a;
				q.b = c;
			end
			q.x1 = pick_coord(scale);
			q.y1 = pick_coord(scale);
			q.x2 = pick_coord(scale);
			q.y2 = pick_coord(scale);
			kind = $urandom_range(0, 9);
			if (kind < 3) begin
				// line through a corner, or one step off it
				cx = $urandom_range(0, 1) ? q.l : q.r;
				cy = $urandom_range(0, 1) ? q.t : q.b;
				cx = cx + $urandom_range(0, 2) - 1;
				cy = cy + $urandom_range(0, 2) - 1;
				dx = $urandom_range(0, 8) - 4;
				dy = $urandom_range(0, 8) - 4;
				k1 = $urandom_range(1, 3);
				k2 = $urandom_range(1, 3);
				q.x1 = cx + k1 * dx;
				q.y1 = cy + k1 * dy;
				q.x2 = cx - k2 * dx;
				q.y2 = cy - k2 * dy;
			end else if (kind == 3) begin
				q.y1 = $urandom_range(0, 1) ? q.t : q.b;
				q.y2 = q.y1;
			end else if (kind == 4) begin
				q.x1 = $urandom_range(0, 1) ? q.l : q.r;
				q.x2 = q.x1;
			end else if (kind == 5) begin
				q.x2 = q.x1;
				q.y2 = q.y1;
			end
			send_req(q, dense);
			if (i == 339)
				dense = 1'b0;
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (hits_pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
